// ===== hdl/pcpo_pkg.sv =====
package pcpo_pkg;

  localparam int unsigned RatioWidth = 10;
  localparam int unsigned CfgDataWidth = 10;
  localparam int unsigned DiffWidth = 9;
  localparam int unsigned GainWidth = 11;
  localparam int unsigned ProdWidth = DiffWidth + GainWidth;
  localparam int unsigned SumWidth = ProdWidth + 1;

  localparam logic [7:0] BW_THRESHOLD_RST = 8'd128;

  localparam logic [7:0] LUMA_WR = 8'd77;
  localparam logic [7:0] LUMA_WG = 8'd150;
  localparam logic [7:0] LUMA_WB = 8'd29;

  localparam logic [7:0] SEPIA_RR = 8'd101;
  localparam logic [7:0] SEPIA_RG = 8'd197;
  localparam logic [7:0] SEPIA_RB = 8'd48;
  localparam logic [7:0] SEPIA_GR = 8'd89;
  localparam logic [7:0] SEPIA_GG = 8'd176;
  localparam logic [7:0] SEPIA_GB = 8'd43;
  localparam logic [7:0] SEPIA_BR = 8'd70;
  localparam logic [7:0] SEPIA_BG = 8'd137;
  localparam logic [7:0] SEPIA_BB = 8'd34;

  typedef enum logic [4:0] {
    MODE_INVERT      = 5'd0,
    MODE_REDUCE      = 5'd1,
    MODE_ENHANCE     = 5'd2,
    MODE_SATURATE    = 5'd3,
    MODE_BRIGHTEN    = 5'd4,
    MODE_DARKEN      = 5'd5,
    MODE_MIX         = 5'd6,
    MODE_GREY        = 5'd7,
    MODE_BW          = 5'd8,
    MODE_INV_GREY    = 5'd9,
    MODE_SEPIA       = 5'd10,
    MODE_RED_ONLY    = 5'd11,
    MODE_GREEN_ONLY  = 5'd12,
    MODE_BLUE_ONLY   = 5'd13,
    MODE_RED_GREY    = 5'd14,
    MODE_GREEN_GREY  = 5'd15,
    MODE_BLUE_GREY   = 5'd16
  } mode_e;

  typedef enum logic [0:0] {
    CFG_RATIO        = 1'b0,
    CFG_BW_THRESHOLD = 1'b1
  } cfg_idx_e;

  typedef logic [7:0] chan_t;
  typedef logic [2:0][7:0] rgb_t;

  typedef struct packed {
    mode_e mode;
    rgb_t  pix;
    rgb_t  sec;
  } in_t;

  typedef struct packed {
    mode_e mode;
    rgb_t  pix;
    rgb_t  sec;
    chan_t grey;
    rgb_t  sepia;
  } luma_t;

  typedef struct packed {
    logic                        mult;
    rgb_t                        base;
    logic [2:0][DiffWidth-1:0]   diff;
    logic [GainWidth-1:0]        gain;
    rgb_t                        direct;
  } sel_t;

  typedef struct packed {
    logic                        mult;
    rgb_t                        base;
    logic [2:0][ProdWidth-1:0]   prod;
    rgb_t                        direct;
  } scale_t;

  // weighted sum of a pixel in q8, shifted down and clamped
  function automatic chan_t weigh(logic [7:0] wr, logic [7:0] wg, logic [7:0] wb, rgb_t p);
    logic [16:0] sum;
    sum = ({9'd0, wr} * {9'd0, p[0]}) + ({9'd0, wg} * {9'd0, p[1]})
        + ({9'd0, wb} * {9'd0, p[2]});
    return sum[16] ? 8'hFF : sum[15:8];
  endfunction

endpackage

// ===== hdl/pcpo_luma.sv =====
module pcpo_luma (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  pcpo_pkg::in_t   data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output pcpo_pkg::luma_t data_o
);
  import pcpo_pkg::*;

  logic  v1_q;
  in_t   d1_q;
  logic  v2_q;
  luma_t d2_q;
  luma_t d2_d;
  logic  ready2;

  assign ready2  = !v2_q || ready_i;
  assign ready_o = !v1_q || ready2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (ready_o) begin
        v1_q <= valid_i;
      end
      if (ready2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      d1_q <= data_i;
    end
    if (ready2 && v1_q) begin
      d2_q <= d2_d;
    end
  end

  always_comb begin
    d2_d.mode     = d1_q.mode;
    d2_d.pix      = d1_q.pix;
    d2_d.sec      = d1_q.sec;
    d2_d.grey     = weigh(LUMA_WR, LUMA_WG, LUMA_WB, d1_q.pix);
    d2_d.sepia[0] = weigh(SEPIA_RR, SEPIA_RG, SEPIA_RB, d1_q.pix);
    d2_d.sepia[1] = weigh(SEPIA_GR, SEPIA_GG, SEPIA_GB, d1_q.pix);
    d2_d.sepia[2] = weigh(SEPIA_BR, SEPIA_BG, SEPIA_BB, d1_q.pix);
  end

  assign valid_o = v2_q;
  assign data_o  = d2_q;

endmodule

// ===== hdl/pcpo_select.sv =====
module pcpo_select (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic signed [pcpo_pkg::RatioWidth-1:0] ratio_i,
  input  logic [7:0]                           bw_threshold_i,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  pcpo_pkg::luma_t                      data_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output pcpo_pkg::sel_t                       data_o
);
  import pcpo_pkg::*;

  logic                 v_q;
  sel_t                 d_q;
  sel_t                 d_d;
  logic [GainWidth-1:0] q_ext;

  assign ready_o = !v_q || ready_i;
  assign q_ext   = {{(GainWidth - RatioWidth){ratio_i[RatioWidth-1]}}, ratio_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      d_q <= d_d;
    end
  end

  always_comb begin
    d_d.mult   = 1'b0;
    d_d.base   = data_i.pix;
    d_d.gain   = q_ext;
    d_d.direct = '0;
    for (int i = 0; i < 3; i++) begin
      d_d.diff[i] = '0;
    end
    unique case (data_i.mode)
      MODE_INVERT: begin
        d_d.direct = ~data_i.pix;
      end
      MODE_REDUCE: begin
        d_d.mult = 1'b1;
        d_d.base = '0;
        for (int i = 0; i < 3; i++) begin
          d_d.diff[i] = {1'b0, data_i.pix[i]};
        end
      end
      MODE_ENHANCE: begin
        d_d.mult = 1'b1;
        for (int i = 0; i < 3; i++) begin
          d_d.diff[i] = {1'b0, ~data_i.pix[i]};
        end
      end
      MODE_SATURATE: begin
        d_d.mult = 1'b1;
        d_d.gain = q_ext + GainWidth'(256);
        for (int i = 0; i < 3; i++) begin
          d_d.base[i] = data_i.grey;
          d_d.diff[i] = {1'b0, data_i.pix[i]} - {1'b0, data_i.grey};
        end
      end
      MODE_BRIGHTEN: begin
        d_d.mult = 1'b1;
        for (int i = 0; i < 3; i++) begin
          d_d.diff[i] = DiffWidth'(255);
        end
      end
      MODE_DARKEN: begin
        d_d.mult = 1'b1;
        d_d.gain = -q_ext;
        for (int i = 0; i < 3; i++) begin
          d_d.diff[i] = DiffWidth'(255);
        end
      end
      MODE_MIX: begin
        d_d.mult = 1'b1;
        for (int i = 0; i < 3; i++) begin
          d_d.diff[i] = {1'b0, data_i.sec[i]} - {1'b0, data_i.pix[i]};
        end
      end
      MODE_GREY: begin
        d_d.direct = {3{data_i.grey}};
      end
      MODE_BW: begin
        d_d.direct = (data_i.grey >= bw_threshold_i) ? {3{8'hFF}} : '0;
      end
      MODE_INV_GREY: begin
        d_d.direct = {3{~data_i.grey}};
      end
      MODE_SEPIA: begin
        d_d.direct = data_i.sepia;
      end
      MODE_RED_ONLY: begin
        d_d.direct[0] = data_i.pix[0];
      end
      MODE_GREEN_ONLY: begin
        d_d.direct[1] = data_i.pix[1];
      end
      MODE_BLUE_ONLY: begin
        d_d.direct[2] = data_i.pix[2];
      end
      MODE_RED_GREY: begin
        d_d.direct = {3{data_i.pix[0]}};
      end
      MODE_GREEN_GREY: begin
        d_d.direct = {3{data_i.pix[1]}};
      end
      MODE_BLUE_GREY: begin
        d_d.direct = {3{data_i.pix[2]}};
      end
      default: begin
        d_d.direct = '0;
      end
    endcase
  end

  assign valid_o = v_q;
  assign data_o  = d_q;

endmodule

// ===== hdl/pcpo_scale.sv =====
module pcpo_scale (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  pcpo_pkg::sel_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output pcpo_pkg::rgb_t data_o
);
  import pcpo_pkg::*;

  logic                       v1_q;
  scale_t                     d1_q;
  scale_t                     d1_d;
  logic                       v2_q;
  rgb_t                       d2_q;
  rgb_t                       d2_d;
  logic                       ready2;
  logic [2:0][SumWidth-1:0]   sum;

  assign ready2  = !v2_q || ready_i;
  assign ready_o = !v1_q || ready2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (ready_o) begin
        v1_q <= valid_i;
      end
      if (ready2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      d1_q <= d1_d;
    end
    if (ready2 && v1_q) begin
      d2_q <= d2_d;
    end
  end

  // signed difference times signed gain
  always_comb begin
    d1_d.mult   = data_i.mult;
    d1_d.base   = data_i.base;
    d1_d.direct = data_i.direct;
    for (int i = 0; i < 3; i++) begin
      d1_d.prod[i] = $signed({{GainWidth{data_i.diff[i][DiffWidth-1]}}, data_i.diff[i]})
                   * $signed({{DiffWidth{data_i.gain[GainWidth-1]}}, data_i.gain});
    end
  end

  // multiply modes: add base in q8, drop fraction, clamp to 0..255; others pass direct
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = {{(SumWidth - 16){1'b0}}, d1_q.base[i], 8'd0}
             + {d1_q.prod[i][ProdWidth-1], d1_q.prod[i]};
      if (!d1_q.mult) begin
        d2_d[i] = d1_q.direct[i];
      end else if (sum[i][SumWidth-1]) begin
        d2_d[i] = 8'd0;
      end else if (|sum[i][SumWidth-2:16]) begin
        d2_d[i] = 8'hFF;
      end else begin
        d2_d[i] = sum[i][15:8];
      end
    end
  end

  assign valid_o = v2_q;
  assign data_o  = d2_q;

endmodule

// ===== hdl/pixel_color_point_ops_unit.sv =====
// pixel color point operations unit
//
// input channel: in_valid_i / in_stall_o with mode_i, the primary pixel
// (red_in_i, green_in_i, blue_in_i) and the second pixel used by mix mode.
// a transfer happens on a rising edge with in_valid_i high and in_stall_o low.
// output channel: out_valid_o / out_stall_i with red_out_o, green_out_o and
// blue_out_o, one result pixel per input pixel, in order.
// configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (0 ratio, signed q8; 1 black/white threshold); write only while idle.
// from input transfer to out_valid_o a pixel passes the five register
// stages (input, luma/sepia, operand select, multiply, clamp), the input
// stage loading at the transfer edge itself.
// throughput: one pixel per cycle with out_stall_i low; a 9x11 bit multiplier per channel.
// reset clears all stage valid bits, ratio to 0 and threshold to 128.
// while out_stall_i is high the output holds; empty stages keep filling and
// in_stall_o rises only when every stage holds a pixel.
module pixel_color_point_ops_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [0:0]                            cfg_idx_i,
  input  logic [pcpo_pkg::CfgDataWidth-1:0]     cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [4:0]                            mode_i,
  input  logic [7:0]                            red_in_i,
  input  logic [7:0]                            green_in_i,
  input  logic [7:0]                            blue_in_i,
  input  logic [7:0]                            second_red_i,
  input  logic [7:0]                            second_green_i,
  input  logic [7:0]                            second_blue_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [7:0]                            red_out_o,
  output logic [7:0]                            green_out_o,
  output logic [7:0]                            blue_out_o
);
  import pcpo_pkg::*;

  logic signed [RatioWidth-1:0] ratio_q;
  logic [7:0]                   bw_threshold_q;

  in_t   in_data;
  logic  in_ready;
  logic  luma_valid;
  logic  luma_ready;
  luma_t luma_data;
  logic  sel_valid;
  logic  sel_ready;
  sel_t  sel_data;
  rgb_t  out_pix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q        <= '0;
      bw_threshold_q <= BW_THRESHOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_RATIO: begin
          ratio_q <= cfg_data_i[RatioWidth-1:0];
        end
        CFG_BW_THRESHOLD: begin
          bw_threshold_q <= cfg_data_i[7:0];
        end
      endcase
    end
  end

  assign in_data.mode = mode_e'(mode_i);
  assign in_data.pix  = {blue_in_i, green_in_i, red_in_i};
  assign in_data.sec  = {second_blue_i, second_green_i, second_red_i};

  pcpo_luma u_luma (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready),
    .data_i  (in_data),
    .valid_o (luma_valid),
    .ready_i (luma_ready),
    .data_o  (luma_data)
  );

  pcpo_select u_select (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ratio_i        (ratio_q),
    .bw_threshold_i (bw_threshold_q),
    .valid_i        (luma_valid),
    .ready_o        (luma_ready),
    .data_i         (luma_data),
    .valid_o        (sel_valid),
    .ready_i        (sel_ready),
    .data_o         (sel_data)
  );

  pcpo_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sel_valid),
    .ready_o (sel_ready),
    .data_i  (sel_data),
    .valid_o (out_valid_o),
    .ready_i (!out_stall_i),
    .data_o  (out_pix)
  );

  assign in_stall_o  = !in_ready;
  assign red_out_o   = out_pix[0];
  assign green_out_o = out_pix[1];
  assign blue_out_o  = out_pix[2];

  // a free output lets every stage advance
  a_free_output_no_stall: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o
  ) else $error("input stalled while output is free");

  // input stalls only with a full pipeline blocked at the output
  a_stall_means_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && luma_valid && sel_valid)
  ) else $error("input stalled with a bubble in the pipeline");

  // a stalled result is kept through the next cycle
  a_result_held: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_pix))
  ) else $error("stalled result lost");

endmodule
